>>> sv/lpfp_pkg.sv
`timescale 1ns / 1ps
// Package with the widths, command and status codes and types of the landmark progression block.
package lpfp_pkg;

    // Field widths of the channel payloads.
    localparam int CMD_W  = 3;
    localparam int ID_W   = 10;
    localparam int ROW_W  = 32;
    localparam int STAT_W = 2;
    localparam int OUT_W  = 32;

    // Command codes of an input transaction.
    localparam logic [CMD_W-1:0] CMD_OP_ROW   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PRED_ROW = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INIT     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PROGRESS = 3'd3;
    localparam logic [CMD_W-1:0] CMD_GOALS    = 3'd4;

    // Status codes of a result transaction.
    localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_VIOLATION = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SELF      = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_PAR,
        S_RD_CHD,
        S_SCAN,
        S_FINISH,
        S_OUT
    } t_state;

    // Port controls of one memory.
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

endpackage

>>> sv/lpfp_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and result items.
interface lpfp_item_if import lpfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ID_W-1:0]   row_index;
    logic [ROW_W-1:0]  row_bits;
    logic [ID_W-1:0]   parent_id;
    logic [ID_W-1:0]   child_id;
    logic [ID_W-1:0]   op_index;

    modport source (output valid, command, row_index, row_bits, parent_id, child_id, op_index,
                    input ready);
    modport sink   (input valid, command, row_index, row_bits, parent_id, child_id, op_index,
                    output ready);
    modport mon    (input valid, ready, command, row_index, row_bits, parent_id, child_id,
                    op_index);
endinterface

interface lpfp_result_if import lpfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [OUT_W-1:0]  past_bits;
    logic [OUT_W-1:0]  future_bits;

    modport source (output valid, status, past_bits, future_bits, input ready);
    modport sink   (input valid, status, past_bits, future_bits, output ready);
    modport mon    (input valid, ready, status, past_bits, future_bits);
endinterface

>>> sv/lpfp_ram.sv
`timescale 1ns / 1ps
// Single write port, single read port memory with registered read data.
module lpfp_ram import lpfp_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  t_mem_ctl      i_ctl,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write and read; read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/lpfp_pred_unit.sv
`timescale 1ns / 1ps
// Predecessor rows in registers and the shared compare that checks one landmark per cycle.
module lpfp_pred_unit #(
    parameter int NL  = 32,
    parameter int LMW = 5
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_we,
    input  logic [LMW-1:0] i_widx,
    input  logic [NL-1:0]  i_wrow,
    input  logic [LMW-1:0] i_idx,
    input  logic [NL-1:0]  i_past,
    output logic           o_unready
);

    logic [NL-1:0] r_pred [NL];

    // Row storage; reset empties every row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NL; i++) begin
                r_pred[i] <= '0;
            end
        end else if (i_we) begin
            r_pred[i_widx] <= i_wrow;
        end
    end

    // A landmark is unready when one of its predecessors is not yet past.
    assign o_unready = |(r_pred[i_idx] & ~i_past);

endmodule

>>> sv/landmark_past_future_progression_top.sv
`timescale 1ns / 1ps
// Top level of the landmark past/future progression block: sequencer, datapath and stores.
//
// Usage: items enter on i_item (valid/ready); each gives exactly one result on o_result.
// Commands load operator rows and predecessor rows, clear a state slot, progress a parent
// state into a child over one operator, or report the past and future landmarks of a state.
// Row writes, init and unused commands go straight to the finishing state; progress with
// child equal to parent reads the masks but skips the scan; other progress and goals read
// the masks and then scan.
// The long path is the predecessor scan: one shared compare checks one landmark per cycle
// against the parent's past mask. The state masks and operator rows sit in memories with
// one write port and one read port, so parent and child masks are read one after the other,
// in the states S_RD_PAR and S_RD_CHD.
// One item is in work at a time; i_item.ready returns the cycle after the result is taken.
// Reset: after i_rst_n is released, a clearing pass writes the reset masks into every state
// slot and every operator row; ready stays low meanwhile.
// Stall: o_result holds its transaction until o_result.ready; no item is taken meanwhile.
module landmark_past_future_progression_top import lpfp_pkg::*; #(
    parameter int NUM_LANDMARKS = 32,
    parameter int NUM_OPERATORS = 1024,
    parameter int NUM_STATES    = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lpfp_item_if.sink      i_item,
    lpfp_result_if.source  o_result
);

    localparam int LW        = NUM_LANDMARKS;
    localparam int ID_SPAN   = 1 << ID_W;
    localparam int ST_DEPTH  = (NUM_STATES < ID_SPAN) ? NUM_STATES : ID_SPAN;
    localparam int OP_DEPTH  = (NUM_OPERATORS < ID_SPAN) ? NUM_OPERATORS : ID_SPAN;
    localparam int ST_AW     = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;
    localparam int OP_AW     = (OP_DEPTH > 1) ? $clog2(OP_DEPTH) : 1;
    localparam int LMW       = (LW > 1) ? $clog2(LW) : 1;
    localparam int CLR_DEPTH = (ST_DEPTH > OP_DEPTH) ? ST_DEPTH : OP_DEPTH;
    localparam int CNT_MAX   = (CLR_DEPTH > LW) ? CLR_DEPTH : LW;
    localparam int CW        = $clog2(CNT_MAX + 1);
    localparam logic [LW-1:0] LM_ONES = '1;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;

    logic [CMD_W-1:0] r_cmd;
    logic [ID_W-1:0]  r_row, r_par, r_chd, r_op;
    logic [LW-1:0]    r_bits;
    logic [LW-1:0]    r_p0, r_f0, r_hits, r_goal;
    logic             r_viol;
    logic [STAT_W-1:0] r_status;
    logic [OUT_W-1:0] r_out_past, r_out_fut;

    logic             acc;
    logic [LW+ROW_W-1:0] row_ext;
    logic [LW-1:0]    row_lm;
    logic             par_ok, chd_ok, op_ok, row_op_ok, row_lm_ok;

    t_mem_ctl         st_ctl, op_ctl;
    logic [ST_AW-1:0] st_waddr, st_raddr;
    logic [OP_AW-1:0] op_waddr, op_raddr;
    logic [LW-1:0]    wpast, wfut, op_wdata;
    logic [LW-1:0]    past_q, fut_q, op_q;
    logic             pred_we, unready;
    logic [LMW-1:0]   scan_idx;

    logic [LW-1:0]    p_edge, f_edge, fin_past, fin_fut;
    logic [STAT_W-1:0] fin_status;
    logic [LW+OUT_W-1:0] past_ext, fut_ext;

    // Handshake and the masked row payload.
    assign acc      = i_item.valid && i_item.ready;
    assign row_ext  = {{LW{1'b0}}, i_item.row_bits};
    assign row_lm   = row_ext[LW-1:0];
    assign scan_idx = r_cnt[LMW-1:0];

    // Range checks on the captured indexes.
    assign par_ok    = 32'(r_par) < NUM_STATES;
    assign chd_ok    = 32'(r_chd) < NUM_STATES;
    assign op_ok     = 32'(r_op) < NUM_OPERATORS;
    assign row_op_ok = 32'(r_row) < NUM_OPERATORS;
    assign row_lm_ok = 32'(r_row) < NUM_LANDMARKS;

    // Past and future masks of the state slots share addresses.
    lpfp_ram #(.DEPTH(ST_DEPTH), .AW(ST_AW), .DW(LW)) u_past_ram (
        .i_clk   (i_clk),
        .i_ctl   (st_ctl),
        .i_waddr (st_waddr),
        .i_wdata (wpast),
        .i_raddr (st_raddr),
        .o_rdata (past_q)
    );

    lpfp_ram #(.DEPTH(ST_DEPTH), .AW(ST_AW), .DW(LW)) u_future_ram (
        .i_clk   (i_clk),
        .i_ctl   (st_ctl),
        .i_waddr (st_waddr),
        .i_wdata (wfut),
        .i_raddr (st_raddr),
        .o_rdata (fut_q)
    );

    lpfp_ram #(.DEPTH(OP_DEPTH), .AW(OP_AW), .DW(LW)) u_op_ram (
        .i_clk   (i_clk),
        .i_ctl   (op_ctl),
        .i_waddr (op_waddr),
        .i_wdata (op_wdata),
        .i_raddr (op_raddr),
        .o_rdata (op_q)
    );

    lpfp_pred_unit #(.NL(LW), .LMW(LMW)) u_pred_unit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (pred_we),
        .i_widx    (r_row[LMW-1:0]),
        .i_wrow    (r_bits),
        .i_idx     (scan_idx),
        .i_past    (r_p0),
        .o_unready (unready)
    );

    // Result of the current item, formed in the finishing cycle.
    always_comb begin
        p_edge     = r_viol ? r_p0 : (r_p0 | r_hits);
        f_edge     = r_viol ? r_f0 : (r_f0 & ~r_hits);
        fin_status = STAT_DONE;
        fin_past   = '0;
        fin_fut    = '0;
        case (r_cmd)
            CMD_INIT: begin
                fin_fut = LM_ONES;
            end
            CMD_PROGRESS: begin
                if (r_chd == r_par) begin
                    fin_status = STAT_SELF;
                    fin_past   = chd_ok ? past_q : '0;
                    fin_fut    = chd_ok ? fut_q : LM_ONES;
                end else begin
                    fin_status = r_viol ? STAT_VIOLATION : STAT_DONE;
                    fin_past   = chd_ok ? (past_q | p_edge) : '0;
                    fin_fut    = chd_ok ? (fut_q & f_edge) : LM_ONES;
                end
            end
            CMD_GOALS: begin
                fin_past = r_p0;
                fin_fut  = r_goal;
            end
            default: begin
                fin_status = STAT_DONE;
            end
        endcase
    end

    assign past_ext = {{OUT_W{1'b0}}, fin_past};
    assign fut_ext  = {{OUT_W{1'b0}}, fin_fut};

    // Sequencer state and counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and memory controls.
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        st_ctl   = '0;
        op_ctl   = '0;
        pred_we  = 1'b0;
        st_waddr = r_chd[ST_AW-1:0];
        st_raddr = r_par[ST_AW-1:0];
        op_waddr = r_row[OP_AW-1:0];
        op_raddr = r_op[OP_AW-1:0];
        wpast    = fin_past;
        wfut     = fin_fut;
        op_wdata = r_bits;
        case (r_state)
            S_CLEAR: begin
                st_waddr  = r_cnt[ST_AW-1:0];
                op_waddr  = r_cnt[OP_AW-1:0];
                wpast     = '0;
                wfut      = LM_ONES;
                op_wdata  = '0;
                st_ctl.we = r_cnt < CW'(ST_DEPTH);
                op_ctl.we = r_cnt < CW'(OP_DEPTH);
                n_cnt     = r_cnt + CW'(1);
                if (r_cnt == CW'(CLR_DEPTH - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    if (i_item.command == CMD_PROGRESS || i_item.command == CMD_GOALS) begin
                        n_state = S_RD_PAR;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_RD_PAR: begin
                st_ctl.re = 1'b1;
                op_ctl.re = 1'b1;
                n_state   = S_RD_CHD;
            end
            S_RD_CHD: begin
                st_ctl.re = 1'b1;
                st_raddr  = r_chd[ST_AW-1:0];
                n_cnt     = '0;
                if (r_cmd == CMD_PROGRESS && r_chd == r_par) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(LW - 1)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_OUT;
                case (r_cmd)
                    CMD_OP_ROW: begin
                        op_ctl.we = row_op_ok;
                    end
                    CMD_PRED_ROW: begin
                        pred_we = row_lm_ok;
                    end
                    CMD_INIT: begin
                        st_ctl.we = chd_ok;
                    end
                    CMD_PROGRESS: begin
                        st_ctl.we = chd_ok && (r_chd != r_par);
                    end
                    default: begin
                        pred_we = 1'b0;
                    end
                endcase
            end
            S_OUT: begin
                if (o_result.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath registers: item capture, parent masks, scan accumulators, result.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    r_cmd  <= i_item.command;
                    r_row  <= i_item.row_index;
                    r_bits <= row_lm;
                    r_par  <= i_item.parent_id;
                    r_chd  <= i_item.child_id;
                    r_op   <= i_item.op_index;
                end
            end
            S_RD_CHD: begin
                r_p0   <= par_ok ? past_q : '0;
                r_f0   <= par_ok ? fut_q : LM_ONES;
                r_hits <= op_ok ? op_q : '0;
                r_viol <= 1'b0;
            end
            S_SCAN: begin
                r_viol           <= r_viol | (r_hits[scan_idx] & unready);
                r_goal[scan_idx] <= ~r_p0[scan_idx] | unready;
            end
            S_FINISH: begin
                r_status   <= fin_status;
                r_out_past <= past_ext[OUT_W-1:0];
                r_out_fut  <= fut_ext[OUT_W-1:0];
            end
            default: begin
                r_viol <= r_viol;
            end
        endcase
    end

    // Channel outputs.
    assign i_item.ready         = (r_state == S_IDLE);
    assign o_result.valid       = (r_state == S_OUT);
    assign o_result.status      = r_status;
    assign o_result.past_bits   = r_out_past;
    assign o_result.future_bits = r_out_fut;

endmodule

>>> sv/lpfp_checker.sv
`timescale 1ns / 1ps
// Port checker for the landmark progression block and its bind to the top level.
module lpfp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_item_valid,
    input logic i_item_ready,
    input logic i_result_valid,
    input logic i_result_ready
);

    // A stalled result stays offered.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result_valid && !i_result_ready |=> i_result_valid)
        else $error("result transaction dropped while stalled");

    // No item is taken while a result waits.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result_valid |-> !i_item_ready)
        else $error("input ready while a result is pending");

    // An item never yields its result in the following cycle.
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item_valid && i_item_ready |=> !i_result_valid)
        else $error("result shown too early after an accepted transaction");

    // A taken result is not repeated.
    a_no_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result_valid && i_result_ready |=> !i_result_valid)
        else $error("result transaction repeated");

    // Reset starts the clearing pass, so no item is taken right after it.
    a_reset_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_item_ready)
        else $error("input ready right after reset");

endmodule

bind landmark_past_future_progression_top lpfp_checker u_lpfp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_item_valid   (i_item.valid),
    .i_item_ready   (i_item.ready),
    .i_result_valid (o_result.valid),
    .i_result_ready (o_result.ready)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the landmark past/future progression block.
module testbench;
    import lpfp_pkg::*;

    localparam int NUM_LM        = 32;
    localparam int NUM_OPS       = 1024;
    localparam int NUM_SLOTS     = 1024;
    localparam int IDLE_PCT      = 23;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int BURST_ITEMS   = 250;
    localparam int PRESSURE_ITEMS = 100;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_MID = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI  = 3'd7;

    // One input transaction and one result transaction.
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [ID_W-1:0]  row_index;
        logic [ROW_W-1:0] row_bits;
        logic [ID_W-1:0]  parent_id;
        logic [ID_W-1:0]  child_id;
        logic [ID_W-1:0]  op_index;
    } t_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OUT_W-1:0]  past_bits;
        logic [OUT_W-1:0]  future_bits;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    lpfp_item_if   item_if ();
    lpfp_result_if result_if ();

    landmark_past_future_progression_top #(
        .NUM_LANDMARKS (NUM_LM),
        .NUM_OPERATORS (NUM_OPS),
        .NUM_STATES    (NUM_SLOTS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    // Shadow copy of the block's stores.
    logic [NUM_LM-1:0] past_masks   [NUM_SLOTS];
    logic [NUM_LM-1:0] future_masks [NUM_SLOTS];
    logic [NUM_LM-1:0] operator_hits [NUM_OPS];
    logic [NUM_LM-1:0] predecessors [NUM_LM];

    t_result pending_results[$];
    int      mismatch_count;
    bit      no_idle;
    bit      hold_request;

    // Clock.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // True when a hit landmark still waits on a predecessor that is not past.
    function automatic bit has_unready_hit(logic [NUM_LM-1:0] hits, logic [NUM_LM-1:0] past);
        bit unready;
        unready = 1'b0;
        for (int b = 0; b < NUM_LM; b++) begin
            if (hits[b] && ((predecessors[b] & ~past) != '0)) unready = 1'b1;
        end
        return unready;
    endfunction

    // Landmarks still ahead: not past, or past with a predecessor that is not.
    function automatic logic [NUM_LM-1:0] open_landmarks(logic [NUM_LM-1:0] past);
        logic [NUM_LM-1:0] open;
        for (int a = 0; a < NUM_LM; a++) begin
            open[a] = !past[a] || ((predecessors[a] & ~past) != '0);
        end
        return open;
    endfunction

    // Applies one transaction to the shadow stores and returns the result it gives.
    function automatic t_result progress_landmarks(t_item it);
        t_result           r;
        logic [NUM_LM-1:0] p0;
        logic [NUM_LM-1:0] f0;
        logic [NUM_LM-1:0] hits;
        r = '0;
        case (it.command)
            CMD_OP_ROW: begin
                operator_hits[it.row_index] = it.row_bits;
            end
            CMD_PRED_ROW: begin
                if (it.row_index < NUM_LM) predecessors[it.row_index[4:0]] = it.row_bits;
            end
            CMD_INIT: begin
                past_masks[it.child_id]   = '0;
                future_masks[it.child_id] = '1;
                r.past_bits   = past_masks[it.child_id];
                r.future_bits = future_masks[it.child_id];
            end
            CMD_PROGRESS: begin
                if (it.child_id == it.parent_id) begin
                    r.status = STAT_SELF;
                end else begin
                    p0   = past_masks[it.parent_id];
                    f0   = future_masks[it.parent_id];
                    hits = operator_hits[it.op_index];
                    if (has_unready_hit(hits, p0)) begin
                        r.status = STAT_VIOLATION;
                    end else begin
                        r.status = STAT_DONE;
                        p0 = p0 | hits;
                        f0 = f0 & ~hits;
                    end
                    past_masks[it.child_id]   = past_masks[it.child_id] | p0;
                    future_masks[it.child_id] = future_masks[it.child_id] & f0;
                end
                r.past_bits   = past_masks[it.child_id];
                r.future_bits = future_masks[it.child_id];
            end
            CMD_GOALS: begin
                r.past_bits   = past_masks[it.parent_id];
                r.future_bits = open_landmarks(r.past_bits);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Sends one transaction, idling at random first, and records its expected result.
    task automatic send_item(t_item it);
        t_result expected;
        while (!no_idle && ($urandom_range(99) < IDLE_PCT)) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid     <= 1'b1;
        item_if.command   <= it.command;
        item_if.row_index <= it.row_index;
        item_if.row_bits  <= it.row_bits;
        item_if.parent_id <= it.parent_id;
        item_if.child_id  <= it.child_id;
        item_if.op_index  <= it.op_index;
        do @(posedge i_clk); while (!item_if.ready);
        expected        = progress_landmarks(it);
        pending_results = {pending_results, expected};
    endtask

    function automatic t_item make_item(logic [CMD_W-1:0] command, logic [ID_W-1:0] row_index,
                                        logic [ROW_W-1:0] row_bits, logic [ID_W-1:0] parent_id,
                                        logic [ID_W-1:0] child_id, logic [ID_W-1:0] op_index);
        t_item it;
        it.command   = command;
        it.row_index = row_index;
        it.row_bits  = row_bits;
        it.parent_id = parent_id;
        it.child_id  = child_id;
        it.op_index  = op_index;
        return it;
    endfunction

    // A mask with a few landmark bits set, so that orderings stay satisfiable.
    function automatic logic [ROW_W-1:0] sparse_mask();
        logic [ROW_W-1:0] m;
        m = '0;
        repeat ($urandom_range(3)) m[$urandom_range(NUM_LM-1)] = 1'b1;
        return m;
    endfunction

    // Mostly slot ids from a small pool so that states chain into each other.
    function automatic logic [ID_W-1:0] pick_slot();
        if ($urandom_range(99) < 85) return ID_W'($urandom_range(15));
        return ID_W'($urandom_range(NUM_SLOTS-1));
    endfunction

    // Random transaction: all fields random, then the used ones shaped by command.
    function automatic t_item random_item();
        t_item       it;
        int unsigned pick;
        it = make_item(CMD_W'($urandom_range(7)), ID_W'($urandom_range(1023)), $urandom(),
                       ID_W'($urandom_range(1023)), ID_W'($urandom_range(1023)),
                       ID_W'($urandom_range(1023)));
        pick = $urandom_range(99);
        if (pick < 8) begin
            it.command = CMD_OP_ROW;
            if ($urandom_range(99) < 80) begin
                it.row_index = ID_W'($urandom_range(31));
                it.row_bits  = sparse_mask();
            end
        end else if (pick < 14) begin
            it.command = CMD_PRED_ROW;
            if ($urandom_range(99) < 85) begin
                it.row_index = ID_W'($urandom_range(NUM_LM-1));
                it.row_bits  = ($urandom_range(3) == 0) ? '0 : sparse_mask();
            end
        end else if (pick < 22) begin
            it.command  = CMD_INIT;
            it.child_id = pick_slot();
        end else if (pick < 77) begin
            it.command   = CMD_PROGRESS;
            it.parent_id = pick_slot();
            it.child_id  = pick_slot();
            if ($urandom_range(99) < 85) it.op_index = ID_W'($urandom_range(31));
        end else if (pick < 95) begin
            it.command   = CMD_GOALS;
            it.parent_id = pick_slot();
        end else begin
            it.command = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        end
        return it;
    endfunction

    // Extremes of the fields, every command and each special case.
    task automatic test_directed();
        send_item(make_item(CMD_GOALS, '0, '0, '0, '0, '0));
        send_item(make_item(CMD_GOALS, '1, '1, '1, '1, '1));
        // Unwritten operator row: nothing is hit.
        send_item(make_item(CMD_PROGRESS, '0, '0, 10'd5, 10'd6, 10'd0));
        send_item(make_item(CMD_OP_ROW, 10'd0, '1, '0, '0, '0));
        send_item(make_item(CMD_OP_ROW, 10'd1023, 32'h0000_0001, '0, '0, '0));
        send_item(make_item(CMD_PRED_ROW, 10'd0, '0, '0, '0, '0));
        send_item(make_item(CMD_PRED_ROW, 10'd31, 32'h0000_0001, '0, '0, '0));
        // Predecessor rows past the last landmark are dropped.
        send_item(make_item(CMD_PRED_ROW, 10'd32, '1, '0, '0, '0));
        send_item(make_item(CMD_PRED_ROW, 10'd1023, '1, '1, '1, '1));
        send_item(make_item(CMD_PROGRESS, '0, '0, 10'd0, 10'd1, 10'd1023));
        // Landmark 31 waits on landmark 0, which slot 0 has not passed.
        send_item(make_item(CMD_PROGRESS, '0, '0, 10'd0, 10'd2, 10'd0));
        send_item(make_item(CMD_PROGRESS, '0, '0, 10'd1, 10'd3, 10'd0));
        send_item(make_item(CMD_PROGRESS, '0, '0, 10'd3, 10'd3, 10'd0));
        send_item(make_item(CMD_GOALS, '0, '0, 10'd1, '0, '0));
        send_item(make_item(CMD_GOALS, '0, '0, 10'd3, '0, '0));
        send_item(make_item(CMD_GOALS, '0, '0, 10'd2, '0, '0));
        send_item(make_item(CMD_PROGRESS, '0, '0, 10'd1023, 10'd3, 10'd1023));
        send_item(make_item(CMD_PROGRESS, '0, '0, 10'd3, 10'd1023, 10'd5));
        send_item(make_item(CMD_INIT, '0, '0, '0, 10'd3, '0));
        send_item(make_item(CMD_GOALS, '0, '0, 10'd3, '0, '0));
        send_item(make_item(CMD_INIT, '1, '1, '1, 10'd1023, '1));
        send_item(make_item(CMD_UNUSED_LO, '1, '1, '1, '1, '1));
        send_item(make_item(CMD_UNUSED_MID, '0, '0, '0, '0, '0));
        send_item(make_item(CMD_UNUSED_HI, '1, '1, '1, '1, '1));
    endtask

    task automatic test_random();
        repeat (RANDOM_ITEMS) send_item(random_item());
    endtask

    // Back to back on both sides.
    task automatic test_burst();
        no_idle = 1'b1;
        repeat (BURST_ITEMS) send_item(random_item());
        no_idle = 1'b0;
    endtask

    // The result side holds off while items keep coming, so the input stalls.
    task automatic test_backpressure();
        hold_request = 1'b1;
        repeat (PRESSURE_ITEMS) send_item(random_item());
    endtask

    // Result sink: random ready, with one long hold-off on request.
    initial begin
        result_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            result_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (result_if.valid && result_if.ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result: expected none, actual %h %h %h", $time,
                         result_if.status, result_if.past_bits, result_if.future_bits);
            end else begin
                want = pending_results.pop_front();
                if (result_if.status !== want.status) begin
                    mismatch_count++;
                    $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                             want.status, result_if.status);
                end
                if (result_if.past_bits !== want.past_bits) begin
                    mismatch_count++;
                    $display("%0t: past_bits mismatch: expected %h, actual %h", $time,
                             want.past_bits, result_if.past_bits);
                end
                if (result_if.future_bits !== want.future_bits) begin
                    mismatch_count++;
                    $display("%0t: future_bits mismatch: expected %h, actual %h", $time,
                             want.future_bits, result_if.future_bits);
                end
            end
        end
    end

    // Watchdog on cycles in which no transaction moves on either channel.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Reset, test sequence and final verdict.
    initial begin
        i_rst_n           = 1'b0;
        item_if.valid     = 1'b0;
        item_if.command   = '0;
        item_if.row_index = '0;
        item_if.row_bits  = '0;
        item_if.parent_id = '0;
        item_if.child_id  = '0;
        item_if.op_index  = '0;
        mismatch_count    = 0;
        no_idle           = 1'b0;
        hold_request      = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            past_masks[i]   = '0;
            future_masks[i] = '1;
        end
        for (int i = 0; i < NUM_OPS; i++) operator_hits[i] = '0;
        for (int i = 0; i < NUM_LM; i++) predecessors[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random();
        test_burst();
        test_backpressure();
        item_if.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
sv/lpfp_pkg.sv
sv/lpfp_if.sv
sv/lpfp_ram.sv
sv/lpfp_pred_unit.sv
sv/landmark_past_future_progression_top.sv
sv/lpfp_checker.sv
dv/testbench.sv
